FILE: sv/spmq_pkg.sv
// Shared types and constants of the strict-priority multi-queue.
// Used by the controller, the datapath, the modulo unit and the top level.
package spmq_pkg;

  localparam int MODE_W     = 2;
  localparam int KIND_W     = 8;
  localparam int TAG_W      = 16;
  localparam int NQ_W       = 4;
  localparam int CAP_W      = 5;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int NQ_RESET  = 8;
  localparam int CAP_RESET = 16;
  localparam int CNT_MAX   = 255;

  // The queue count never exceeds 15, so a remainder always fits in four bits.
  localparam int REM_W          = 4;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS      = KIND_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_PEEK = 2'd1,
    MODE_DEQ  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_QUEUES     = 1'b0,
    CFG_QUEUE_CAPACITY = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_ENQUEUE,
    ST_SELECT,
    ST_FETCH,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic enqueue;
    logic select;
    logic fetch;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

FILE: sv/spmq_mod.sv
// Iterative modulo unit: kind modulo the active queue count, two bits per step cycle.
// Depends on spmq_pkg.
module spmq_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic                       step,
  input  logic [spmq_pkg::KIND_W-1:0] kind,
  input  logic [spmq_pkg::REM_W:0]   divisor,
  output logic [spmq_pkg::REM_W-1:0] remainder,
  output logic                       last
);
  import spmq_pkg::*;

  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     rem_next;
  logic [KIND_W-1:0]    bits;
  logic [KIND_W-1:0]    bits_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W:0]       part;

  always_comb begin
    rem_next  = rem;
    bits_next = bits;
    part      = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      part      = {rem_next, bits_next[KIND_W-1]};
      bits_next = bits_next << 1;
      if (part >= divisor) begin
        part = part - divisor;
      end
      rem_next = part[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= '0;
      bits <= kind;
    end else if (step) begin
      rem  <= rem_next;
      bits <= bits_next;
    end
  end

  assign last      = (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign remainder = rem;

endmodule

FILE: sv/spmq_dpath.sv
// Datapath: configuration registers, queue pointers and fills, tag memory and results.
// Depends on spmq_pkg and spmq_mod.
module spmq_dpath #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  spmq_pkg::dp_cmd_t              cmd,
  output spmq_pkg::dp_status_t           status,
  input  logic                           cfg_write,
  input  logic [spmq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spmq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [spmq_pkg::MODE_W-1:0]    mode,
  input  logic [spmq_pkg::KIND_W-1:0]    packet_kind,
  input  logic [spmq_pkg::TAG_W-1:0]     packet_tag,
  output logic [spmq_pkg::TAG_W-1:0]     out_tag,
  output logic                           out_valid,
  output logic                           dropped,
  output logic                           all_empty,
  output logic [spmq_pkg::CNT_W-1:0]     total_count
);
  import spmq_pkg::*;

  localparam int QW      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = MAX_QUEUES * QUEUE_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TW      = $clog2(ENTRIES + 1);
  localparam int CMPW    = (FW > CAP_W) ? FW : CAP_W;

  logic [NQ_W-1:0]   num_queues;
  logic [CAP_W-1:0]  queue_capacity;
  logic [NQ_W:0]     active_q;

  mode_t             mode_r;
  logic [TAG_W-1:0]  tag_r;

  logic [PW-1:0]     head_ptr [MAX_QUEUES];
  logic [PW-1:0]     tail_ptr [MAX_QUEUES];
  logic [FW-1:0]     fill     [MAX_QUEUES];
  logic [TW-1:0]     total;

  logic [TAG_BITS-1:0] tag_mem [ENTRIES];
  logic [TAG_BITS-1:0] rd_data;

  logic [REM_W-1:0]  mod_rem;
  logic [QW-1:0]     enq_q;
  logic              enq_room;
  logic [AW-1:0]     enq_addr;
  logic [PW-1:0]     enq_tail_next;

  logic [MAX_QUEUES-1:0] nonempty;
  logic [QW-1:0]     sel_q;
  logic              sel_found;
  logic [AW-1:0]     sel_addr;

  logic [QW-1:0]     head_queue;
  logic              head_found;
  logic [PW-1:0]     deq_head_next;

  logic [TAG_W-1:0]  res_tag;
  logic              res_valid;
  logic              res_drop;

  spmq_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.load),
    .step      (cmd.div_step),
    .kind      (packet_kind),
    .divisor   (active_q),
    .remainder (mod_rem),
    .last      (status.div_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_queues     <= NQ_W'(NQ_RESET);
      queue_capacity <= CAP_W'(CAP_RESET);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NUM_QUEUES:     num_queues     <= cfg_data[NQ_W-1:0];
        CFG_QUEUE_CAPACITY: queue_capacity <= cfg_data[CAP_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (num_queues == '0) begin
      active_q = (NQ_W+1)'(1);
    end else if ({1'b0, num_queues} > (NQ_W+1)'(MAX_QUEUES)) begin
      active_q = (NQ_W+1)'(MAX_QUEUES);
    end else begin
      active_q = {1'b0, num_queues};
    end
  end

  // Enqueue side.
  assign enq_q    = mod_rem[QW-1:0];
  assign enq_room = (fill[enq_q] != FW'(QUEUE_DEPTH)) &&
                    (CMPW'(fill[enq_q]) < CMPW'(queue_capacity));
  assign enq_addr = AW'(int'(enq_q) * QUEUE_DEPTH + int'(tail_ptr[enq_q]));
  assign enq_tail_next = (tail_ptr[enq_q] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : tail_ptr[enq_q] + 1'b1;

  // Head selection: lowest-numbered active queue that holds a packet.
  always_comb begin
    for (int q = 0; q < MAX_QUEUES; q++) begin
      nonempty[q] = (fill[q] != '0) && ((NQ_W+1)'(q) < active_q);
    end
  end

  always_comb begin
    sel_q     = '0;
    sel_found = 1'b0;
    for (int q = MAX_QUEUES - 1; q >= 0; q--) begin
      if (nonempty[q]) begin
        sel_q     = QW'(q);
        sel_found = 1'b1;
      end
    end
  end

  assign sel_addr = AW'(int'(sel_q) * QUEUE_DEPTH + int'(head_ptr[sel_q]));
  assign deq_head_next = (head_ptr[head_queue] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                        : head_ptr[head_queue] + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.enqueue && enq_room) begin
      tag_mem[enq_addr] <= TAG_BITS'(tag_r);
    end
    if (cmd.select) begin
      rd_data <= tag_mem[sel_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(mode);
      tag_r  <= packet_tag;
    end
    if (cmd.select) begin
      head_queue <= sel_q;
      head_found <= sel_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < MAX_QUEUES; q++) begin
        head_ptr[q] <= '0;
        tail_ptr[q] <= '0;
        fill[q]     <= '0;
      end
      total <= '0;
    end else if (cmd.enqueue && enq_room) begin
      tail_ptr[enq_q] <= enq_tail_next;
      fill[enq_q]     <= fill[enq_q] + 1'b1;
      total           <= total + 1'b1;
    end else if (cmd.fetch && head_found && (mode_r == MODE_DEQ)) begin
      head_ptr[head_queue] <= deq_head_next;
      fill[head_queue]     <= fill[head_queue] - 1'b1;
      total                <= total - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_tag   <= '0;
      res_valid <= 1'b0;
      res_drop  <= 1'b0;
    end else if (cmd.enqueue) begin
      res_drop <= !enq_room;
    end else if (cmd.fetch && head_found) begin
      res_tag   <= TAG_W'(rd_data);
      res_valid <= 1'b1;
    end
  end

  assign out_tag     = res_tag;
  assign out_valid   = res_valid;
  assign dropped     = res_drop;
  assign all_empty   = (total == '0);
  assign total_count = (int'(total) > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(total);

endmodule

FILE: sv/spmq_ctrl.sv
// Controller state machine sequencing each request through the datapath.
// Depends on spmq_pkg.
module spmq_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spmq_pkg::MODE_W-1:0] mode,
  input  spmq_pkg::dp_status_t        status,
  output spmq_pkg::dp_cmd_t           cmd,
  output logic                        busy,
  output logic                        done
);
  import spmq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == ST_IDLE) || (state == ST_RESULT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = !ready;
    done       = (state == ST_RESULT);
    unique case (state)
      ST_IDLE, ST_RESULT: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (mode_t'(mode))
            MODE_ENQ:            state_next = ST_DIVIDE;
            MODE_PEEK, MODE_DEQ: state_next = ST_SELECT;
            MODE_NOP:            state_next = ST_RESULT;
          endcase
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_ENQUEUE;
        end
      end
      ST_ENQUEUE: begin
        cmd.enqueue = 1'b1;
        state_next  = ST_RESULT;
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_RESULT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/strict_priority_multi_queue.sv
// Top level of the strict-priority multi-queue with tail drop.
// Depends on spmq_pkg, spmq_ctrl and spmq_dpath.
//
// A request is taken when start is high and busy is low; its single result is
// presented for exactly one cycle with done high and must be captured then, as
// the block cannot be held off. An enqueue is captured on acceptance, runs the
// two-bit-per-cycle modulo of the kind by the queue count, then updates the
// queue; its result overlaps the next acceptance. A peek or dequeue passes the
// select and fetch states, as the tag memory read is registered; a no-operation
// request goes straight to its result. Queue state is ready straight after
// reset. The user must write configuration only while idle; it is not enforced.
module strict_priority_multi_queue #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  output logic                            done,
  input  logic [spmq_pkg::MODE_W-1:0]     mode,
  input  logic [spmq_pkg::KIND_W-1:0]     packet_kind,
  input  logic [spmq_pkg::TAG_W-1:0]      packet_tag,
  output logic [spmq_pkg::TAG_W-1:0]      out_tag,
  output logic                            out_valid,
  output logic                            dropped,
  output logic                            all_empty,
  output logic [spmq_pkg::CNT_W-1:0]      total_count,
  input  logic                            cfg_write,
  input  logic [spmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spmq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spmq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  spmq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  spmq_dpath #(
    .MAX_QUEUES  (MAX_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .packet_kind (packet_kind),
    .packet_tag  (packet_tag),
    .out_tag     (out_tag),
    .out_valid   (out_valid),
    .dropped     (dropped),
    .all_empty   (all_empty),
    .total_count (total_count)
  );

endmodule
